@@ rtl/core/srp_pkg.sv @@
// Shared types, constants and register codes of the shelf rectangle packer.
package srp_pkg;

  // Field and register widths.
  localparam int DimW  = 15;
  localparam int CurW  = 16;
  localparam int PadW  = 8;
  localparam int AddrW = 5;
  localparam int DataW = 32;

  // Largest height that a doubling may ever produce.
  localparam int DIM_LIMIT = 16384;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_ATLAS_WIDTH = 3'd0;
  localparam logic [2:0] REG_INIT_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MAX_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_PAD_X       = 3'd3;
  localparam logic [2:0] REG_PAD_Y       = 3'd4;
  localparam logic [2:0] REG_SIZE_LOCKED = 3'd5;

  // Request operation codes.
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_TOO_WIDE    = 2'd1,
    ST_LOCKED      = 2'd2,
    ST_RESIZE_FAIL = 2'd3
  } status_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [DimW-1:0] atlas_width;
    logic [DimW-1:0] initial_height;
    logic [DimW-1:0] max_height;
    logic [PadW-1:0] pad_x;
    logic [PadW-1:0] pad_y;
    logic            size_locked;
  } srp_cfg_t;

  // Register values that take effect at the next edge, with the restart flag.
  typedef struct packed {
    logic     restart;
    srp_cfg_t regs;
  } srp_cfg_upd_t;

  localparam srp_cfg_t CFG_RESET = '{
    atlas_width:    15'd1024,
    initial_height: 15'd256,
    max_height:     15'd16384,
    pad_x:          8'd1,
    pad_y:          8'd1,
    size_locked:    1'b0
  };

endpackage

@@ rtl/core/srp_if.sv @@
// Request and result channel interfaces of the shelf rectangle packer.
interface srp_req_if;
  import srp_pkg::*;
  logic            valid;
  logic            ready;
  logic            op;
  logic [DimW-1:0] rect_width;
  logic [DimW-1:0] rect_height;

  modport source (output valid, output op, output rect_width, output rect_height,
                  input ready);
  modport sink   (input valid, input op, input rect_width, input rect_height,
                  output ready);
endinterface

interface srp_rsp_if;
  import srp_pkg::*;
  logic            valid;
  logic            ready;
  logic [1:0]      status;
  logic [DimW-1:0] place_x;
  logic [DimW-1:0] place_y;
  logic [DimW-1:0] current_height;

  modport source (output valid, output status, output place_x, output place_y,
                  output current_height, input ready);
  modport sink   (input valid, input status, input place_x, input place_y,
                  input current_height, output ready);
endinterface

@@ rtl/core/srp_cfg.sv @@
// APB register file of the shelf rectangle packer.
module srp_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srp_pkg::AddrW-1:0]   paddr,
  input  logic [srp_pkg::DataW-1:0]   pwdata,
  output logic [srp_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output srp_pkg::srp_cfg_t           cfg,
  output srp_pkg::srp_cfg_upd_t       cfg_upd
);
  import srp_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel && penable && pwrite;

  // Next values; a new initial height or padding restarts the packer.
  always_comb begin
    cfg_upd.regs    = cfg;
    cfg_upd.restart = 1'b0;
    if (wr_en) begin
      unique case (idx)
        REG_ATLAS_WIDTH: cfg_upd.regs.atlas_width = pwdata[DimW-1:0];
        REG_INIT_HEIGHT: begin
          cfg_upd.regs.initial_height = pwdata[DimW-1:0];
          cfg_upd.restart             = 1'b1;
        end
        REG_MAX_HEIGHT:  cfg_upd.regs.max_height = pwdata[DimW-1:0];
        REG_PAD_X: begin
          cfg_upd.regs.pad_x = pwdata[PadW-1:0];
          cfg_upd.restart    = 1'b1;
        end
        REG_PAD_Y: begin
          cfg_upd.regs.pad_y = pwdata[PadW-1:0];
          cfg_upd.restart    = 1'b1;
        end
        REG_SIZE_LOCKED: cfg_upd.regs.size_locked = pwdata[0];
        default: ;
      endcase
    end
  end

  // Register storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else begin
      cfg <= cfg_upd.regs;
    end
  end

  // Read data, zero extended.
  always_comb begin
    unique case (idx)
      REG_ATLAS_WIDTH: prdata = DataW'(cfg.atlas_width);
      REG_INIT_HEIGHT: prdata = DataW'(cfg.initial_height);
      REG_MAX_HEIGHT:  prdata = DataW'(cfg.max_height);
      REG_PAD_X:       prdata = DataW'(cfg.pad_x);
      REG_PAD_Y:       prdata = DataW'(cfg.pad_y);
      REG_SIZE_LOCKED: prdata = DataW'(cfg.size_locked);
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/srp_place.sv @@
// Shelf placement logic: cursor state, fit tests and the result register.
module srp_place (
  input  logic                  clk,
  input  logic                  rst,
  srp_req_if.sink               req,
  srp_rsp_if.source             rsp,
  input  srp_pkg::srp_cfg_t     cfg,
  input  srp_pkg::srp_cfg_upd_t cfg_upd
);
  import srp_pkg::*;

  // Packer state.
  logic [CurW-1:0] cursor_x;
  logic [CurW-1:0] cursor_y;
  logic [DimW-1:0] row_tallest;
  logic [DimW-1:0] height_now;
  logic            any_placed;

  logic            accept;
  logic            too_wide;
  logic            over_y;
  logic            over_x;
  logic            over_row;
  logic            grow;
  logic            wrap;
  logic            too_big;
  logic            place_ok;
  logic [CurW:0]   doubled;
  logic [CurW+1:0] row_sum;
  logic [CurW-1:0] row_y;
  logic [CurW-1:0] base_x;
  logic [CurW-1:0] base_y;
  logic [DimW-1:0] base_tall;
  logic [CurW+1:0] adv_sum;
  logic [CurW-1:0] adv_x;
  logic [DimW-1:0] height_next;
  status_t         status_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Fit tests, all done wide enough that nothing wraps.
  always_comb begin
    too_wide = req.rect_width > cfg.atlas_width;
    over_y   = (17'(req.rect_height) + 17'(cursor_y)) > 17'(height_now);
    over_x   = (17'(req.rect_width) + 17'(cursor_x)) > 17'(cfg.atlas_width);
    over_row = (18'(req.rect_height) + 18'(row_tallest) + 18'(cursor_y))
               > 18'(height_now);
    grow     = over_y || (over_x && over_row);
    wrap     = !over_y && over_x && !over_row;
    doubled  = {2'b00, height_now} << 1;
    too_big  = (doubled > 17'(cfg.max_height)) || (doubled > 17'(DIM_LIMIT));
  end

  // Status of a place request.
  always_comb begin
    priority if (too_wide) begin
      status_next = ST_TOO_WIDE;
    end else if (grow && cfg.size_locked) begin
      status_next = ST_LOCKED;
    end else if (grow && too_big) begin
      status_next = ST_RESIZE_FAIL;
    end else begin
      status_next = ST_OK;
    end
    place_ok = (req.op == OP_PLACE) && (status_next == ST_OK);
  end

  // Position after an optional new row, and the cursor advance past the rectangle.
  always_comb begin
    row_sum   = 18'(cursor_y) + 18'(row_tallest) + 18'(cfg.pad_y);
    row_y     = (row_sum > 18'({CurW{1'b1}})) ? {CurW{1'b1}} : row_sum[CurW-1:0];
    base_x    = (grow || wrap) ? CurW'(cfg.pad_x) : cursor_x;
    base_y    = (grow || wrap) ? row_y : cursor_y;
    base_tall = (grow || wrap) ? '0 : row_tallest;
    adv_sum   = 18'(base_x) + 18'(req.rect_width) + 18'(cfg.pad_x);
    adv_x     = (adv_sum > 18'({CurW{1'b1}})) ? {CurW{1'b1}} : adv_sum[CurW-1:0];
    height_next = (place_ok && grow) ? doubled[DimW-1:0] : height_now;
  end

  // State registers: reset, restart on a configuration write, then requests.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= CurW'(CFG_RESET.pad_x);
      cursor_y    <= CurW'(CFG_RESET.pad_y);
      row_tallest <= '0;
      height_now  <= CFG_RESET.initial_height;
      any_placed  <= 1'b0;
    end else if (cfg_upd.restart) begin
      cursor_x    <= CurW'(cfg_upd.regs.pad_x);
      cursor_y    <= CurW'(cfg_upd.regs.pad_y);
      row_tallest <= '0;
      height_now  <= cfg_upd.regs.initial_height;
      any_placed  <= 1'b0;
    end else if (accept) begin
      if (req.op == OP_CLEAR) begin
        if (any_placed) begin
          cursor_x    <= CurW'(cfg.pad_x);
          cursor_y    <= CurW'(cfg.pad_y);
          row_tallest <= '0;
          any_placed  <= 1'b0;
        end
      end else if (place_ok) begin
        cursor_x    <= adv_x;
        cursor_y    <= base_y;
        row_tallest <= (req.rect_height > base_tall) ? req.rect_height : base_tall;
        height_now  <= height_next;
        any_placed  <= 1'b1;
      end
    end
  end

  // Result register; a result holds until taken, which lets the next request in.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
    if (accept) begin
      rsp.status         <= (req.op == OP_CLEAR) ? ST_OK : status_next;
      rsp.place_x        <= place_ok ? base_x[DimW-1:0] : '0;
      rsp.place_y        <= place_ok ? base_y[DimW-1:0] : '0;
      rsp.current_height <= height_next;
    end
  end

`ifndef SYNTH
  // A clear always reports success with a zero offset.
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    accept && (req.op == OP_CLEAR) |=>
      rsp.valid && (rsp.status == ST_OK) && (rsp.place_x == '0) && (rsp.place_y == '0))
    else $error("clear request did not give a clean success result");

  // A refused request carries no placement offset.
  a_error_no_offset: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != ST_OK) |-> (rsp.place_x == '0) && (rsp.place_y == '0))
    else $error("error result carries a placement offset");

  // The placed flag drops only on a clear, a restart or a reset.
  a_placed_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(any_placed) |->
      $past(rst) || $past(cfg_upd.restart) || $past(accept && (req.op == OP_CLEAR)))
    else $error("placed flag dropped without a clear or restart");

  // The height moves only on an accepted request, a restart or a reset.
  a_height_change: assert property (@(posedge clk) disable iff (rst)
    !$stable(height_now) |-> $past(rst) || $past(cfg_upd.restart) || $past(accept))
    else $error("atlas height changed without a request");
`endif

endmodule

@@ rtl/core/shelf_rectangle_packer_top.sv @@
// Top level of the shelf rectangle packer: APB registers and placement logic.
//
// The packer places rectangles into an atlas row by row and takes one request
// in every clock cycle while results are taken as they appear. A result is
// registered in the cycle after acceptance; while it waits, the next request
// is accepted in the same cycle that it leaves. The rate is set by the
// combinational fit test and cursor update on the state registers. Registers
// lie at byte address 4*i; writing the initial height or either padding
// restarts the packer with the new values. The user must write configuration
// only while no request is outstanding; the block does not enforce it.
module shelf_rectangle_packer_top (
  input  logic                      clk,
  input  logic                      rst,
  srp_req_if.sink                   req,
  srp_rsp_if.source                 rsp,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [srp_pkg::AddrW-1:0] paddr,
  input  logic [srp_pkg::DataW-1:0] pwdata,
  output logic [srp_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import srp_pkg::*;

  srp_cfg_t     cfg;
  srp_cfg_upd_t cfg_upd;

  // Configuration registers.
  srp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_upd (cfg_upd)
  );

  // Placement logic and result register.
  srp_place u_place (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cfg     (cfg),
    .cfg_upd (cfg_upd)
  );

endmodule

@@ verif/shelf_rectangle_packer_top_tb.sv @@
// Self-checking testbench of the shelf rectangle packer: directed table, then random phases.
module shelf_rectangle_packer_top_tb;
  import srp_pkg::*;

  // Kinds of rows in the directed table.
  localparam logic ROW_ITEM = 1'b0;
  localparam logic ROW_REG  = 1'b1;

  localparam int PLAN_LEN    = 31;
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 200;

  // One placement result as the block reports it.
  typedef struct packed {
    status_t         status;
    logic [DimW-1:0] place_x;
    logic [DimW-1:0] place_y;
    logic [DimW-1:0] current_height;
  } placement_t;

  // One row of the directed table: a register write or a request.
  typedef struct {
    logic            kind;
    logic [2:0]      reg_idx;
    logic [31:0]     reg_val;
    logic            op;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
    logic            typed;
    status_t         status;
    logic [DimW-1:0] x;
    logic [DimW-1:0] y;
  } plan_row_t;

  logic             clk;
  logic             rst;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  srp_req_if req_ch ();
  srp_rsp_if rsp_ch ();

  shelf_rectangle_packer_top u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted packer state and the register values it works with.
  srp_cfg_t    cfg_now;
  int unsigned shelf_x;
  int unsigned shelf_y;
  int unsigned shelf_tallest;
  int unsigned atlas_height;
  bit          anything_placed;

  placement_t  placement_q[$];
  int          mismatch_count;

  // Typed expectation of the request currently offered, if it has one.
  logic            offer_typed;
  status_t         offer_status;
  logic [DimW-1:0] offer_x;
  logic [DimW-1:0] offer_y;

  bit no_stall;
  bit backlog_hold;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout guard for a hung handshake.
  initial begin : watchdog
    #6000000;
    $display("shelf_rectangle_packer_top regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function void restart_packer();
    shelf_x         = 32'(cfg_now.pad_x);
    shelf_y         = 32'(cfg_now.pad_y);
    shelf_tallest   = 0;
    atlas_height    = 32'(cfg_now.initial_height);
    anything_placed = 1'b0;
  endfunction

  function void open_shelf();
    shelf_y       = shelf_y + shelf_tallest + 32'(cfg_now.pad_y);
    shelf_y       = (shelf_y > 65535) ? 65535 : shelf_y;
    shelf_x       = 32'(cfg_now.pad_x);
    shelf_tallest = 0;
  endfunction

  // Mirror a register write; initial height and the paddings restart the packer.
  function void apply_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_ATLAS_WIDTH: cfg_now.atlas_width = v[DimW-1:0];
      REG_INIT_HEIGHT: begin
        cfg_now.initial_height = v[DimW-1:0];
        restart_packer();
      end
      REG_MAX_HEIGHT:  cfg_now.max_height = v[DimW-1:0];
      REG_PAD_X: begin
        cfg_now.pad_x = v[PadW-1:0];
        restart_packer();
      end
      REG_PAD_Y: begin
        cfg_now.pad_y = v[PadW-1:0];
        restart_packer();
      end
      REG_SIZE_LOCKED: cfg_now.size_locked = v[0];
      default: ;
    endcase
  endfunction

  // Work out the placement of one request and advance the predicted state.
  function placement_t place_rect(logic op, logic [DimW-1:0] w_in, logic [DimW-1:0] h_in);
    placement_t  res;
    int unsigned w;
    int unsigned h;
    int unsigned doubled;
    bit          grow;
    bit          fits;
    w = 32'(w_in);
    h = 32'(h_in);
    grow = 1'b0;
    fits = 1'b1;
    res.status  = ST_OK;
    res.place_x = '0;
    res.place_y = '0;
    if (op == OP_CLEAR) begin
      if (anything_placed) begin
        shelf_x         = 32'(cfg_now.pad_x);
        shelf_y         = 32'(cfg_now.pad_y);
        shelf_tallest   = 0;
        anything_placed = 1'b0;
      end
    end else if (w > cfg_now.atlas_width) begin
      res.status = ST_TOO_WIDE;
    end else begin
      // A cursor already past the height never fits, since nothing wraps here.
      if (h + shelf_y > atlas_height) begin
        grow = 1'b1;
      end else if (w + shelf_x > cfg_now.atlas_width) begin
        if (h + shelf_tallest + shelf_y > atlas_height) grow = 1'b1;
        else open_shelf();
      end
      if (grow) begin
        doubled = atlas_height * 2;
        if (cfg_now.size_locked) begin
          res.status = ST_LOCKED;
          fits = 1'b0;
        end else if (doubled > cfg_now.max_height || doubled > DIM_LIMIT) begin
          res.status = ST_RESIZE_FAIL;
          fits = 1'b0;
        end else begin
          atlas_height = doubled & 32'h7FFF;
          open_shelf();
        end
      end
      if (fits) begin
        res.place_x     = shelf_x[DimW-1:0];
        res.place_y     = shelf_y[DimW-1:0];
        shelf_x         = shelf_x + w + 32'(cfg_now.pad_x);
        shelf_x         = (shelf_x > 65535) ? 65535 : shelf_x;
        shelf_tallest   = (h > shelf_tallest) ? h : shelf_tallest;
        anything_placed = 1'b1;
      end
    end
    res.current_height = atlas_height[DimW-1:0];
    return res;
  endfunction

  function void check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
    end
  endfunction

  // Score results against the oldest expectation, then predict newly accepted requests.
  always @(posedge clk) begin : scoreboard
    placement_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (placement_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request pending: status %0d x %0d y %0d height %0d",
                   $time, rsp_ch.status, rsp_ch.place_x, rsp_ch.place_y,
                   rsp_ch.current_height);
        end else begin
          want = placement_q.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_ch.status));
          check_field("place_x", 32'(want.place_x), 32'(rsp_ch.place_x));
          check_field("place_y", 32'(want.place_y), 32'(rsp_ch.place_y));
          check_field("current_height", 32'(want.current_height),
                      32'(rsp_ch.current_height));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        want = place_rect(req_ch.op, req_ch.rect_width, req_ch.rect_height);
        if (offer_typed) begin
          want.status  = offer_status;
          want.place_x = offer_x;
          want.place_y = offer_y;
        end
        placement_q.push_back(want);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    bit hold_used;
    stall_left = 0;
    hold_left  = 0;
    hold_used  = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (backlog_hold && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_request(input logic op, input logic [DimW-1:0] w,
                              input logic [DimW-1:0] h, input logic typed,
                              input status_t st, input logic [DimW-1:0] x,
                              input logic [DimW-1:0] y);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.rect_width  <= w;
    req_ch.rect_height <= h;
    offer_typed  = typed;
    offer_status = st;
    offer_x      = x;
    offer_y      = y;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic drain_requests();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write a register once the block is idle, then read it back.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
    logic [31:0] readback;
    drain_requests();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_reg(idx, v);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ATLAS_WIDTH: readback = 32'(cfg_now.atlas_width);
      REG_INIT_HEIGHT: readback = 32'(cfg_now.initial_height);
      REG_MAX_HEIGHT:  readback = 32'(cfg_now.max_height);
      REG_PAD_X:       readback = 32'(cfg_now.pad_x);
      REG_PAD_Y:       readback = 32'(cfg_now.pad_y);
      default:         readback = 32'(cfg_now.size_locked);
    endcase
    if (prdata !== readback) begin
      mismatch_count++;
      $display("%0t: register %0d readback: expected %0d, actual %0d",
               $time, idx, readback, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin : stimulus
    plan_row_t       plan [PLAN_LEN];
    logic [31:0]     aw, ih, mh, px, py, lk;
    logic            op;
    logic [DimW-1:0] w, h;
    int              pick;

    rst = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.op          = OP_PLACE;
    req_ch.rect_width  = '0;
    req_ch.rect_height = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    offer_typed  = 1'b0;
    offer_status = ST_OK;
    offer_x      = '0;
    offer_y      = '0;
    no_stall       = 1'b0;
    backlog_hold   = 1'b0;
    mismatch_count = 0;
    cfg_now = CFG_RESET;
    restart_packer();

    // Directed cases: reset values, extremes, every error, clears and cursor saturation.
    plan = '{
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd0, 15'd0, 1'b1, ST_OK, 15'd1, 15'd1},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd1025, 15'd5, 1'b1, ST_TOO_WIDE, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'h7FFF, 15'h7FFF, 1'b1, ST_TOO_WIDE, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_CLEAR, 15'd0, 15'd0, 1'b1, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd1024, 15'd10, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd100, 15'd300, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_CLEAR, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_CLEAR, 15'h7FFF, 15'h7FFF, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_REG, REG_SIZE_LOCKED, 32'd1, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd10, 15'd5000, 1'b1, ST_LOCKED, 15'd0, 15'd0},
      '{ROW_REG, REG_SIZE_LOCKED, 32'd0, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_REG, REG_MAX_HEIGHT, 32'd600, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd10, 15'd5000, 1'b1, ST_RESIZE_FAIL, 15'd0, 15'd0},
      '{ROW_REG, REG_MAX_HEIGHT, 32'd16384, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_REG, REG_INIT_HEIGHT, 32'd16384, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd0, 15'd16384, 1'b1, ST_RESIZE_FAIL, 15'd0, 15'd0},
      '{ROW_REG, REG_ATLAS_WIDTH, 32'd1, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd1, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd2, 15'd0, 1'b1, ST_TOO_WIDE, 15'd0, 15'd0},
      '{ROW_REG, REG_PAD_X, 32'd0, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_REG, REG_PAD_Y, 32'd0, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd1, 15'd1, 1'b1, ST_OK, 15'd0, 15'd0},
      '{ROW_REG, REG_ATLAS_WIDTH, 32'd16384, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_REG, REG_PAD_X, 32'd255, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_REG, REG_PAD_Y, 32'd255, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_REG, REG_INIT_HEIGHT, 32'd1, OP_PLACE, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd16384, 15'h7FFF, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd0, 15'h7FFF, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd0, 15'h7FFF, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_PLACE, 15'd0, 15'h7FFF, 1'b0, ST_OK, 15'd0, 15'd0},
      '{ROW_ITEM, 3'd0, 32'd0, OP_CLEAR, 15'd0, 15'd0, 1'b0, ST_OK, 15'd0, 15'd0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_REG) begin
        reg_write(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_request(plan[i].op, plan[i].w, plan[i].h, plan[i].typed,
                     plan[i].status, plan[i].x, plan[i].y);
      end
    end

    // Random phases, each under a fresh setting; the first two are the extremes.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) begin
        aw = 1; ih = 1; mh = 1; px = 0; py = 0; lk = 0;
      end else if (ph == 1) begin
        aw = 16384; ih = 16384; mh = 16384; px = 255; py = 255; lk = 0;
      end else begin
        aw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16384) : $urandom_range(1, 64);
        ih = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 64);
        mh = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16384) : 16384;
        px = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        py = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        lk = 32'(ph == 2 || $urandom_range(0, 7) == 0);
      end
      reg_write(REG_MAX_HEIGHT, mh);
      reg_write(REG_ATLAS_WIDTH, aw);
      reg_write(REG_SIZE_LOCKED, lk);
      reg_write(REG_PAD_X, px);
      reg_write(REG_PAD_Y, py);
      reg_write(REG_INIT_HEIGHT, ih);

      no_stall = (ph % 4 == 3);
      if (ph == 5) backlog_hold = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        op = OP_PLACE;
        w  = DimW'($urandom_range(0, 32767));
        h  = DimW'($urandom_range(0, 32767));
        // Mostly requests that fit the atlas, so shelves fill and the height grows.
        if (pick < 5) begin
          op = OP_CLEAR;
        end else if (pick >= 13) begin
          w = (pick < 18) ? cfg_now.atlas_width
                          : DimW'($urandom_range(0, cfg_now.atlas_width));
          if (pick < 28) h = DimW'($urandom_range(0, 2 * atlas_height));
          else h = DimW'($urandom_range(0, atlas_height / 4));
        end
        send_request(op, w, h, 1'b0, ST_OK, '0, '0);
      end
    end

    drain_requests();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("shelf_rectangle_packer_top regression: pass");
    end else begin
      $display("shelf_rectangle_packer_top regression: fail");
    end
    $finish;
  end

endmodule
